// ===== design/pub_pkg.sv =====
// Shared types, constants and helpers for the proportional usage bar cells block.
package pub_pkg;

  localparam int HARD_MAX_CELLS = 4096;
  localparam int UNIT_W         = 32;
  localparam int TOT_W          = 34;
  localparam int CNT_W          = 13;
  localparam int IDX_W          = 12;
  localparam int DIV_STEP       = 4;
  localparam int QR_STAGES      = (TOT_W + DIV_STEP - 1) / DIV_STEP;
  localparam int QR_W           = QR_STAGES * DIV_STEP;
  localparam int REM_W          = CNT_W;
  localparam int FR_W           = 24;
  localparam int FR_STAGES      = FR_W / DIV_STEP;

  typedef enum logic [2:0] {
    REG_ACTIVE   = 3'd0,
    REG_HOLE     = 3'd1,
    REG_RESERVED = 3'd2,
    REG_MAX      = 3'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_ACTIVE   = 2'd0,
    KIND_HOLE     = 2'd1,
    KIND_RESERVED = 2'd2,
    KIND_MIXED    = 2'd3
  } kind_t;

  typedef struct packed {
    logic             ok;
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] idx1;
  } tag_t;

  function automatic logic [REM_W+DIV_STEP-1:0] div_step(
    input logic [REM_W-1:0]    rem,
    input logic [DIV_STEP-1:0] bits,
    input logic [CNT_W-1:0]    d
  );
    logic [REM_W:0]        w;
    logic [REM_W-1:0]      r;
    logic [DIV_STEP-1:0]   q;
    r = rem;
    q = '0;
    for (int k = DIV_STEP - 1; k >= 0; k--) begin
      w = {r, bits[k]};
      if (w >= {1'b0, d}) begin
        w = w - {1'b0, d};
        q[k] = 1'b1;
      end
      r = w[REM_W-1:0];
    end
    return {r, q};
  endfunction

endpackage

// ===== design/pub_cfg.sv =====
// Configuration registers and derived totals and cell count.
module pub_cfg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  input  logic [2:0]                cfg_index,
  input  logic [31:0]               cfg_data,
  output logic [pub_pkg::UNIT_W-1:0] act_end,
  output logic [pub_pkg::UNIT_W:0]   hole_end,
  output logic [pub_pkg::TOT_W-1:0]  tot,
  output logic [pub_pkg::CNT_W-1:0]  n
);
  import pub_pkg::*;

  logic [UNIT_W-1:0] act_r, act_nxt;
  logic [UNIT_W-1:0] hole_r, hole_nxt;
  logic [UNIT_W-1:0] res_r, res_nxt;
  logic [15:0]       max_r, max_nxt;
  logic [UNIT_W:0]   hend_r, hend_nxt;
  logic [TOT_W-1:0]  tot_r, tot_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [CNT_W-1:0]  mcl;

  always_comb begin
    act_nxt  = act_r;
    hole_nxt = hole_r;
    res_nxt  = res_r;
    max_nxt  = max_r;
    if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_ACTIVE:   act_nxt  = cfg_data[UNIT_W-1:0];
        REG_HOLE:     hole_nxt = cfg_data[UNIT_W-1:0];
        REG_RESERVED: res_nxt  = cfg_data[UNIT_W-1:0];
        REG_MAX:      max_nxt  = cfg_data[15:0];
        default: ;
      endcase
    end
    hend_nxt = {1'b0, act_nxt} + {1'b0, hole_nxt};
    tot_nxt  = {1'b0, hend_nxt} + {2'b0, res_nxt};
    mcl      = (max_nxt > 16'(HARD_MAX_CELLS)) ? CNT_W'(HARD_MAX_CELLS) : max_nxt[CNT_W-1:0];
    n_nxt    = (tot_nxt < TOT_W'(mcl)) ? tot_nxt[CNT_W-1:0] : mcl;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= '0;
      hole_r <= '0;
      res_r  <= '0;
      max_r  <= '0;
      hend_r <= '0;
      tot_r  <= '0;
      n_r    <= '0;
    end else begin
      act_r  <= act_nxt;
      hole_r <= hole_nxt;
      res_r  <= res_nxt;
      max_r  <= max_nxt;
      hend_r <= hend_nxt;
      tot_r  <= tot_nxt;
      n_r    <= n_nxt;
    end
  end

  assign act_end  = act_r;
  assign hole_end = hend_r;
  assign tot      = tot_r;
  assign n        = n_r;

endmodule

// ===== design/pub_qr.sv =====
// Pipelined divider for total over cell count, four quotient bits per stage.
module pub_qr (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic                      in_vld,
  input  logic [pub_pkg::IDX_W-1:0] idx,
  input  logic [pub_pkg::TOT_W-1:0] tot,
  input  logic [pub_pkg::CNT_W-1:0] n,
  output logic                      o_vld,
  output pub_pkg::tag_t             o_tag,
  output logic [pub_pkg::TOT_W-1:0] o_q,
  output logic [pub_pkg::IDX_W-1:0] o_r
);
  import pub_pkg::*;

  logic [QR_STAGES-1:0]  vld_r;
  tag_t                  tag_r [QR_STAGES];
  logic [REM_W-1:0]      rem_r [QR_STAGES];
  logic [QR_W-1:0]       q_r   [QR_STAGES];
  logic [REM_W+DIV_STEP-1:0] stp [QR_STAGES];
  logic [QR_W-1:0]       tot_x;
  tag_t                  tag0;

  always_comb begin
    tot_x     = QR_W'(tot);
    tag0.ok   = ({1'b0, idx} < n);
    tag0.idx  = idx;
    tag0.idx1 = {1'b0, idx} + CNT_W'(1);
    for (int s = 0; s < QR_STAGES; s++) begin
      stp[s] = div_step((s == 0) ? REM_W'(0) : rem_r[(s == 0) ? 0 : s - 1],
                        tot_x[QR_W-1-DIV_STEP*s -: DIV_STEP], n);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[QR_STAGES-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag_r[0] <= tag0;
      rem_r[0] <= stp[0][REM_W+DIV_STEP-1:DIV_STEP];
      q_r[0]   <= QR_W'(stp[0][DIV_STEP-1:0]);
      for (int s = 1; s < QR_STAGES; s++) begin
        tag_r[s] <= tag_r[s-1];
        rem_r[s] <= stp[s][REM_W+DIV_STEP-1:DIV_STEP];
        q_r[s]   <= {q_r[s-1][QR_W-DIV_STEP-1:0], stp[s][DIV_STEP-1:0]};
      end
    end
  end

  assign o_vld = vld_r[QR_STAGES-1];
  assign o_tag = tag_r[QR_STAGES-1];
  assign o_q   = q_r[QR_STAGES-1][TOT_W-1:0];
  assign o_r   = rem_r[QR_STAGES-1][IDX_W-1:0];

endmodule

// ===== design/pub_frac.sv =====
// Multiply stage and two-lane pipelined divider for the cell boundaries.
module pub_frac (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic                      in_vld,
  input  pub_pkg::tag_t             in_tag,
  input  logic [pub_pkg::TOT_W-1:0] q,
  input  logic [pub_pkg::IDX_W-1:0] r,
  input  logic [pub_pkg::CNT_W-1:0] n,
  output logic                      o_vld,
  output pub_pkg::tag_t             o_tag,
  output logic [pub_pkg::TOT_W-1:0] o_qi,
  output logic [pub_pkg::TOT_W-1:0] o_qi1,
  output logic [pub_pkg::CNT_W-1:0] o_f0,
  output logic [pub_pkg::CNT_W-1:0] o_f1
);
  import pub_pkg::*;

  localparam int PW = TOT_W + CNT_W;

  logic                  m_vld_r;
  tag_t                  m_tag_r;
  logic [TOT_W-1:0]      m_qi_r, m_qi1_r;
  logic [FR_W-1:0]       m_ri_r, m_ri1_r;
  logic [PW-1:0]         p_qi, p_qi1;

  logic [FR_STAGES-1:0]  vld_r;
  tag_t                  tag_r [FR_STAGES];
  logic [TOT_W-1:0]      qi_r  [FR_STAGES];
  logic [TOT_W-1:0]      qi1_r [FR_STAGES];
  logic [REM_W-1:0]      rm0_r [FR_STAGES];
  logic [REM_W-1:0]      rm1_r [FR_STAGES];
  logic [FR_W-1:0]       x0_r  [FR_STAGES];
  logic [FR_W-1:0]       x1_r  [FR_STAGES];
  logic [REM_W+DIV_STEP-1:0] st0 [FR_STAGES];
  logic [REM_W+DIV_STEP-1:0] st1 [FR_STAGES];

  assign p_qi  = PW'(q) * PW'(in_tag.idx);
  assign p_qi1 = PW'(q) * PW'(in_tag.idx1);

  always_comb begin
    st0[0] = div_step(REM_W'(0), m_ri_r[FR_W-1 -: DIV_STEP], n);
    st1[0] = div_step(REM_W'(0), m_ri1_r[FR_W-1 -: DIV_STEP], n);
    for (int s = 1; s < FR_STAGES; s++) begin
      st0[s] = div_step(rm0_r[s-1], x0_r[s-1][FR_W-1 -: DIV_STEP], n);
      st1[s] = div_step(rm1_r[s-1], x1_r[s-1][FR_W-1 -: DIV_STEP], n);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
      vld_r   <= '0;
    end else if (adv) begin
      m_vld_r <= in_vld;
      vld_r   <= {vld_r[FR_STAGES-2:0], m_vld_r};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tag_r  <= in_tag;
      m_qi_r   <= p_qi[TOT_W-1:0];
      m_qi1_r  <= p_qi1[TOT_W-1:0];
      m_ri_r   <= FR_W'(r) * FR_W'(in_tag.idx);
      m_ri1_r  <= FR_W'(r) * FR_W'(in_tag.idx1);
      tag_r[0] <= m_tag_r;
      qi_r[0]  <= m_qi_r;
      qi1_r[0] <= m_qi1_r;
      rm0_r[0] <= st0[0][REM_W+DIV_STEP-1:DIV_STEP];
      rm1_r[0] <= st1[0][REM_W+DIV_STEP-1:DIV_STEP];
      x0_r[0]  <= {m_ri_r[FR_W-DIV_STEP-1:0], st0[0][DIV_STEP-1:0]};
      x1_r[0]  <= {m_ri1_r[FR_W-DIV_STEP-1:0], st1[0][DIV_STEP-1:0]};
      for (int s = 1; s < FR_STAGES; s++) begin
        tag_r[s] <= tag_r[s-1];
        qi_r[s]  <= qi_r[s-1];
        qi1_r[s] <= qi1_r[s-1];
        rm0_r[s] <= st0[s][REM_W+DIV_STEP-1:DIV_STEP];
        rm1_r[s] <= st1[s][REM_W+DIV_STEP-1:DIV_STEP];
        x0_r[s]  <= {x0_r[s-1][FR_W-DIV_STEP-1:0], st0[s][DIV_STEP-1:0]};
        x1_r[s]  <= {x1_r[s-1][FR_W-DIV_STEP-1:0], st1[s][DIV_STEP-1:0]};
      end
    end
  end

  assign o_vld = vld_r[FR_STAGES-1];
  assign o_tag = tag_r[FR_STAGES-1];
  assign o_qi  = qi_r[FR_STAGES-1];
  assign o_qi1 = qi1_r[FR_STAGES-1];
  assign o_f0  = x0_r[FR_STAGES-1][CNT_W-1:0];
  assign o_f1  = x1_r[FR_STAGES-1][CNT_W-1:0];

endmodule

// ===== design/pub_tail.sv =====
// Boundary sums, overlap counts, kind code and output register.
module pub_tail (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic                       in_vld,
  input  pub_pkg::tag_t              in_tag,
  input  logic [pub_pkg::TOT_W-1:0]  qi,
  input  logic [pub_pkg::TOT_W-1:0]  qi1,
  input  logic [pub_pkg::CNT_W-1:0]  f0,
  input  logic [pub_pkg::CNT_W-1:0]  f1,
  input  logic [pub_pkg::UNIT_W-1:0] act_end,
  input  logic [pub_pkg::UNIT_W:0]   hole_end,
  input  logic [pub_pkg::TOT_W-1:0]  tot,
  input  logic [pub_pkg::CNT_W-1:0]  n,
  output logic                       o_vld,
  output logic                       o_valid_res,
  output logic [pub_pkg::CNT_W-1:0]  o_cell_count,
  output logic [pub_pkg::TOT_W-1:0]  o_first_unit,
  output logic [pub_pkg::TOT_W-1:0]  o_unit_count,
  output logic [pub_pkg::UNIT_W-1:0] o_active_count,
  output logic [pub_pkg::UNIT_W-1:0] o_hole_count,
  output logic [pub_pkg::UNIT_W-1:0] o_reserved_count,
  output logic [1:0]                 o_kind
);
  import pub_pkg::*;

  logic             a_vld_r;
  logic             a_ok_r;
  logic [TOT_W-1:0] a_first_r, a_end_r;

  logic             vld_r;
  logic             vres_r;
  logic [CNT_W-1:0] cnt_r;
  logic [TOT_W-1:0] first_r, len_r;
  logic [UNIT_W-1:0] ac_r, hc_r, rc_r;
  kind_t            kind_r;

  logic [TOT_W-1:0] ae, he;
  logic [TOT_W-1:0] lo_a, hi_a, lo_h, hi_h, lo_r, hi_r;
  logic             nz_a, nz_h, nz_r;
  logic [TOT_W-1:0] d_a, d_h, d_r;
  kind_t            kind_c;

  always_comb begin
    ae   = TOT_W'(act_end);
    he   = TOT_W'(hole_end);
    lo_a = a_first_r;
    hi_a = (a_end_r < ae) ? a_end_r : ae;
    lo_h = (a_first_r > ae) ? a_first_r : ae;
    hi_h = (a_end_r < he) ? a_end_r : he;
    lo_r = (a_first_r > he) ? a_first_r : he;
    hi_r = (a_end_r < tot) ? a_end_r : tot;
    nz_a = hi_a > lo_a;
    nz_h = hi_h > lo_h;
    nz_r = hi_r > lo_r;
    d_a  = nz_a ? hi_a - lo_a : '0;
    d_h  = nz_h ? hi_h - lo_h : '0;
    d_r  = nz_r ? hi_r - lo_r : '0;
    if ($countones({nz_a, nz_h, nz_r}) > 1) begin
      kind_c = KIND_MIXED;
    end else if (nz_a) begin
      kind_c = KIND_ACTIVE;
    end else if (nz_h) begin
      kind_c = KIND_HOLE;
    end else begin
      kind_c = KIND_RESERVED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      vld_r   <= 1'b0;
    end else if (adv) begin
      a_vld_r <= in_vld;
      vld_r   <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_ok_r    <= in_tag.ok;
      a_first_r <= qi + TOT_W'(f0);
      a_end_r   <= qi1 + TOT_W'(f1);
      vres_r    <= a_ok_r;
      cnt_r     <= n;
      if (a_ok_r) begin
        first_r <= a_first_r;
        len_r   <= a_end_r - a_first_r;
        ac_r    <= d_a[UNIT_W-1:0];
        hc_r    <= d_h[UNIT_W-1:0];
        rc_r    <= d_r[UNIT_W-1:0];
        kind_r  <= kind_c;
      end else begin
        first_r <= '0;
        len_r   <= '0;
        ac_r    <= '0;
        hc_r    <= '0;
        rc_r    <= '0;
        kind_r  <= KIND_ACTIVE;
      end
    end
  end

  assign o_vld            = vld_r;
  assign o_valid_res      = vres_r;
  assign o_cell_count     = cnt_r;
  assign o_first_unit     = first_r;
  assign o_unit_count     = len_r;
  assign o_active_count   = ac_r;
  assign o_hole_count     = hc_r;
  assign o_reserved_count = rc_r;
  assign o_kind           = kind_r;

endmodule

// ===== design/proportional_usage_bar_cells.sv =====
// Top level of the proportional usage bar cells block.
//
//  channel  direction  handshake           payload
//  in       input      in_valid/in_stall   in_cell_index
//  out      output     out_valid/out_stall out_valid_res .. out_kind
//  cfg      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// One item per cycle while the output is not stalled; each item passes through
// 9 divider stages for total over cell count, one multiply stage, 6 divider
// stages for the fractional boundaries, then sum and overlap stages.
// Reset clears the configuration registers and all valid bits; data registers are not reset.
// A stalled output freezes the whole pipeline; in_stall follows it.
module proportional_usage_bar_cells (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [pub_pkg::IDX_W-1:0]  in_cell_index,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_valid_res,
  output logic [pub_pkg::CNT_W-1:0]  out_cell_count,
  output logic [pub_pkg::TOT_W-1:0]  out_first_unit,
  output logic [pub_pkg::TOT_W-1:0]  out_unit_count,
  output logic [pub_pkg::UNIT_W-1:0] out_active_count,
  output logic [pub_pkg::UNIT_W-1:0] out_hole_count,
  output logic [pub_pkg::UNIT_W-1:0] out_reserved_count,
  output logic [1:0]                 out_kind,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [2:0]                 cfg_index,
  input  logic [31:0]                cfg_data
);
  import pub_pkg::*;

  logic              adv;
  logic [UNIT_W-1:0] act_end;
  logic [UNIT_W:0]   hole_end;
  logic [TOT_W-1:0]  tot;
  logic [CNT_W-1:0]  n;

  logic              qr_vld;
  tag_t              qr_tag;
  logic [TOT_W-1:0]  qr_q;
  logic [IDX_W-1:0]  qr_r;

  logic              fr_vld;
  tag_t              fr_tag;
  logic [TOT_W-1:0]  fr_qi, fr_qi1;
  logic [CNT_W-1:0]  fr_f0, fr_f1;

  assign adv       = !out_valid || !out_stall;
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  pub_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .act_end   (act_end),
    .hole_end  (hole_end),
    .tot       (tot),
    .n         (n)
  );

  pub_qr u_qr (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .in_vld (in_valid),
    .idx    (in_cell_index),
    .tot    (tot),
    .n      (n),
    .o_vld  (qr_vld),
    .o_tag  (qr_tag),
    .o_q    (qr_q),
    .o_r    (qr_r)
  );

  pub_frac u_frac (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .in_vld (qr_vld),
    .in_tag (qr_tag),
    .q      (qr_q),
    .r      (qr_r),
    .n      (n),
    .o_vld  (fr_vld),
    .o_tag  (fr_tag),
    .o_qi   (fr_qi),
    .o_qi1  (fr_qi1),
    .o_f0   (fr_f0),
    .o_f1   (fr_f1)
  );

  pub_tail u_tail (
    .clk              (clk),
    .rst_n            (rst_n),
    .adv              (adv),
    .in_vld           (fr_vld),
    .in_tag           (fr_tag),
    .qi               (fr_qi),
    .qi1              (fr_qi1),
    .f0               (fr_f0),
    .f1               (fr_f1),
    .act_end          (act_end),
    .hole_end         (hole_end),
    .tot              (tot),
    .n                (n),
    .o_vld            (out_valid),
    .o_valid_res      (out_valid_res),
    .o_cell_count     (out_cell_count),
    .o_first_unit     (out_first_unit),
    .o_unit_count     (out_unit_count),
    .o_active_count   (out_active_count),
    .o_hole_count     (out_hole_count),
    .o_reserved_count (out_reserved_count),
    .o_kind           (out_kind)
  );

endmodule

// ===== design/pub_chk.sv =====
// Port-level checker for the proportional usage bar cells block and its bind.
module pub_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic                       out_valid_res,
  input logic [pub_pkg::CNT_W-1:0]  out_cell_count,
  input logic [pub_pkg::TOT_W-1:0]  out_first_unit,
  input logic [pub_pkg::TOT_W-1:0]  out_unit_count,
  input logic [pub_pkg::UNIT_W-1:0] out_active_count,
  input logic [pub_pkg::UNIT_W-1:0] out_hole_count,
  input logic [pub_pkg::UNIT_W-1:0] out_reserved_count,
  input logic [1:0]                 out_kind
);
  import pub_pkg::*;

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_first_unit))
    else $error("result changed while stalled");

  a_empty_cell: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_valid_res |-> out_unit_count == '0 && out_first_unit == '0
      && out_kind == KIND_ACTIVE)
    else $error("out of range cell not cleared");

  a_split_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_valid_res |-> out_unit_count ==
      TOT_W'(out_active_count) + TOT_W'(out_hole_count) + TOT_W'(out_reserved_count))
    else $error("kind counts do not add up to cell length");

  a_count_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_valid_res |-> out_cell_count != '0 && out_unit_count != '0)
    else $error("valid cell with zero count");

endmodule

bind proportional_usage_bar_cells pub_chk u_pub_chk (.*);

// ===== tb/proportional_usage_bar_cells_checker.sv =====
// Checker for the usage bar cells block: predicts each cell query and compares results.
`timescale 1ns / 1ps
module proportional_usage_bar_cells_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [11:0] in_cell_index,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_valid_res,
  input  logic [12:0] out_cell_count,
  input  logic [33:0] out_first_unit,
  input  logic [33:0] out_unit_count,
  input  logic [31:0] out_active_count,
  input  logic [31:0] out_hole_count,
  input  logic [31:0] out_reserved_count,
  input  logic [1:0]  out_kind,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  import pub_pkg::*;

  typedef struct packed {
    logic        ok;
    logic [12:0] n;
    logic [33:0] first;
    logic [33:0] len;
    logic [31:0] ac;
    logic [31:0] hc;
    logic [31:0] rc;
    logic [1:0]  kind;
  } cell_t;

  logic [31:0] act_r, hole_r, res_r;
  logic [15:0] max_r;
  cell_t cell_q[$];

  function automatic logic [63:0] bound(logic [63:0] i, logic [63:0] t, logic [63:0] n);
    return (t / n) * i + ((t % n) * i) / n;
  endfunction

  function automatic logic [63:0] span(logic [63:0] a0, logic [63:0] a1,
                                       logic [63:0] b0, logic [63:0] b1);
    logic [63:0] lo, hi;
    lo = a0 > b0 ? a0 : b0;
    hi = a1 < b1 ? a1 : b1;
    return hi > lo ? hi - lo : 0;
  endfunction

  function automatic cell_t predict_cell(logic [11:0] idx);
    cell_t c;
    logic [63:0] t, n, f, e, ae, he;
    int k;
    c = '0;
    t = 64'(act_r) + 64'(hole_r) + 64'(res_r);
    n = 0;
    if (t != 0 && max_r != 0) begin
      n = 64'(max_r) < HARD_MAX_CELLS ? 64'(max_r) : HARD_MAX_CELLS;
      if (t < n) n = t;
    end
    c.n = n[12:0];
    if (64'(idx) < n) begin
      f = bound(64'(idx), t, n);
      e = bound(64'(idx) + 1, t, n);
      ae = 64'(act_r);
      he = ae + 64'(hole_r);
      c.ok = 1'b1;
      c.first = f[33:0];
      c.len = 34'(e - f);
      c.ac = 32'(span(f, e, 0, ae));
      c.hc = 32'(span(f, e, ae, he));
      c.rc = 32'(span(f, e, he, t));
      k = (c.ac != 0) + (c.hc != 0) + (c.rc != 0);
      if (k > 1) c.kind = KIND_MIXED;
      else if (c.ac != 0) c.kind = KIND_ACTIVE;
      else if (c.hc != 0) c.kind = KIND_HOLE;
      else c.kind = KIND_RESERVED;
    end
    return c;
  endfunction

  assign pending = cell_q.size();

  always @(posedge clk) begin
    cell_t want, got;
    if (!rst_n) begin
      act_r <= '0; hole_r <= '0; res_r <= '0; max_r <= '0;
      fail_count <= 0;
      cell_q.delete();
    end else begin
      if (in_valid && !in_stall) cell_q = {cell_q, predict_cell(in_cell_index)};
      if (out_valid && !out_stall) begin
        got = {out_valid_res, out_cell_count, out_first_unit, out_unit_count,
               out_active_count, out_hole_count, out_reserved_count, out_kind};
        if (cell_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = cell_q.pop_front();
          if (want !== got) begin
            if (fail_count < 10)
              $display({"mismatch: exp ok=%0d n=%0d f=%0d l=%0d a=%0d h=%0d r=%0d k=%0d",
                        " / got ok=%0d n=%0d f=%0d l=%0d a=%0d h=%0d r=%0d k=%0d"},
                want.ok, want.n, want.first, want.len, want.ac, want.hc, want.rc, want.kind,
                got.ok, got.n, got.first, got.len, got.ac, got.hc, got.rc, got.kind);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ACTIVE:   act_r <= cfg_data;
          REG_HOLE:     hole_r <= cfg_data;
          REG_RESERVED: res_r <= cfg_data;
          REG_MAX:      max_r <= cfg_data[15:0];
          default: ;
        endcase
      end
    end
  end
endmodule

// ===== tb/proportional_usage_bar_cells_test.sv =====
// Testbench top for the usage bar cells block: stimulus, configuration phases and verdict.
`timescale 1ns / 1ps
module proportional_usage_bar_cells_test;
  import pub_pkg::*;

  localparam logic [2:0] REG_NONE = 3'd5;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [11:0] in_cell_index;
  logic out_valid_res;
  logic [12:0] out_cell_count;
  logic [33:0] out_first_unit, out_unit_count;
  logic [31:0] out_active_count, out_hole_count, out_reserved_count;
  logic [1:0] out_kind;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;
  int fail_count, pending, cycles, sent, phases;

  proportional_usage_bar_cells DUT (.*);
  proportional_usage_bar_cells_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // random output stall, drawn per result
  initial begin
    int w;
    out_stall = 1'b0;
    forever begin
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      repeat (w) @(posedge clk) out_stall <= 1'b1;
      @(posedge clk) out_stall <= 1'b0;
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic send_cell(logic [11:0] idx, bit gaps);
    int w;
    w = gaps ? $urandom_range(0, 13) : 0;
    if (w > 0) begin
      in_valid <= 1'b0;
      repeat (w) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cell_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_units();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return $urandom_range(1, 20);
      2: return 32'hFFFF_FFFF;
      3: return $urandom_range(1, 5000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_max();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return $urandom_range(1, 16);
      2: return 16'hFFFF;
      3: return 4096;
      4: return {$urandom} | 32'hFFFF_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic setup(logic [31:0] a, logic [31:0] h, logic [31:0] r, logic [31:0] m);
    write_reg(REG_ACTIVE, a);
    write_reg(REG_HOLE, h);
    write_reg(REG_RESERVED, r);
    write_reg(REG_MAX, m);
    write_reg(REG_NONE, $urandom);
    cfg_valid <= 1'b0;
    phases++;
  endtask

  initial begin
    logic [11:0] ix;
    in_valid = 0; in_cell_index = 0;
    cfg_valid = 0; cfg_index = 0; cfg_data = 0;
    sent = 0; phases = 0;
    rst_n = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // reset registers: empty range
    send_cell(12'd0, 1'b0);
    send_cell(12'hFFF, 1'b0);
    drain();
    setup(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF);
    send_cell(12'd0, 1'b0); send_cell(12'hFFF, 1'b0);
    send_cell(12'hAAA, 1'b0); send_cell(12'h555, 1'b0);
    drain();
    setup(32'd3, 32'd2, 32'd1, 32'd10);
    for (int i = 0; i < 7; i++) send_cell(12'(i), 1'b0);
    drain();
    setup(32'd5, 32'd0, 32'd7, 32'd0);
    send_cell(12'd0, 1'b0);
    drain();
    setup(32'd0, 32'd9, 32'd0, 32'd4);
    send_cell(12'd0, 1'b0); send_cell(12'd3, 1'b0); send_cell(12'd4, 1'b0);
    drain();
    while (sent < 720) begin
      setup(pick_units(), pick_units(), pick_units(), pick_max());
      for (int i = $urandom_range(20, 60); i > 0; i--) begin
        ix = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 40));
        send_cell(ix, $urandom_range(0, 4) != 0);
      end
      drain();
    end
    $display("%0d cell queries over %0d register settings", sent, phases);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule

// ===== filelist.f =====
design/pub_pkg.sv
design/pub_cfg.sv
design/pub_qr.sv
design/pub_frac.sv
design/pub_tail.sv
design/proportional_usage_bar_cells.sv
design/pub_chk.sv
tb/proportional_usage_bar_cells_checker.sv
tb/proportional_usage_bar_cells_test.sv
